[hdl/multicart_mmc3_bank_mapper_assert.svh]
// Assertion macros for the multicart MMC3 bank mapper checker.
// Used by mcmmc3_chk; expects signals clk and rst_n in scope.
`ifndef MULTICART_MMC3_BANK_MAPPER_ASSERT_SVH
`define MULTICART_MMC3_BANK_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define MCMMC3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcmmc3 assertion failed");

// Delayed implication, disabled in reset
`define MCMMC3_ASSERT_D2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("mcmmc3 latency assertion failed");

`endif

[hdl/mcmmc3_pkg.sv]
// Package for the multicart MMC3 bank mapper: transaction types and constants.
// No dependencies.
package mcmmc3_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_PRG   = 2'd1,
    REQ_CHR   = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [9:0] bank;
    logic       write_taken;
  } out_item_t;

  // Configuration register indexes
  localparam logic CFG_PRG_LAST = 1'b0;
  localparam logic CFG_CHR_LAST = 1'b1;

  localparam logic [7:0] PRG_LAST_RST = 8'd63;
  localparam logic [9:0] CHR_LAST_RST = 10'd255;

  // Write decode
  localparam logic [15:0] WR_MASK   = 16'hF001;
  localparam logic [15:0] WR_BSEL   = 16'h8000;
  localparam logic [15:0] WR_BDATA  = 16'h8001;
  localparam logic [15:0] WR_OUT_90 = 16'h9000;
  localparam logic [15:0] WR_OUT_91 = 16'h9001;
  localparam logic [15:0] WR_OUT_B0 = 16'hB000;
  localparam logic [15:0] WR_OUT_B1 = 16'hB001;
  localparam logic [15:0] WR_OUT_D0 = 16'hD000;
  localparam logic [15:0] WR_OUT_D1 = 16'hD001;
  localparam logic [15:0] WR_OUT_F0 = 16'hF000;
  localparam logic [15:0] WR_OUT_F1 = 16'hF001;

  // Fixed program banks
  localparam logic [7:0] PRG_FIX_E = 8'h0E;
  localparam logic [7:0] PRG_FIX_F = 8'h0F;

  // Bank register reset contents
  localparam logic [7:0] BANK_INIT [8] = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd0};

endpackage

[hdl/multicart_mmc3_bank_mapper.sv]
// Multicart MMC3 bank mapper top level: register writes and bank translation.
// Depends on mcmmc3_pkg.
//
// Every transaction on in_item is taken when start is high (busy is never
// raised). Its single result is shown on out_item with out_valid high for one
// cycle: the transaction is captured in the input register, decoded and
// translated out of it, and the answer is captured in the result register,
// which drives out_item and out_valid.
// One transaction per cycle is sustained; the receiver cannot stall, so it
// must take each result in the cycle it is shown. A write updates the mapper
// registers as it leaves the input register, so the next transaction already
// sees it. Configuration writes via cfg_we/cfg_index/cfg_wdata take effect at
// once and belong in idle periods.
module multicart_mmc3_bank_mapper (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  mcmmc3_pkg::in_item_t   in_item,
  output logic                   out_valid,
  output mcmmc3_pkg::out_item_t  out_item,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [9:0]             cfg_wdata
);
  import mcmmc3_pkg::*;

  logic        in_vld_r;
  in_item_t    in_item_r;
  logic        out_vld_r;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;

  logic [7:0]  prg_last_r;
  logic [9:0]  chr_last_r;
  logic [7:0]  outer_r;
  logic [7:0]  bsel_r;
  logic [7:0]  bank_regs_r [8];

  logic        wr_outer;
  logic        wr_bsel;
  logic        wr_bdata;
  logic [15:0] wr_code;

  logic [1:0]  prg_slot;
  logic [7:0]  prg_v;
  logic [7:0]  prg_raw;
  logic [7:0]  prg_bank;

  logic [2:0]  chr_slot;
  logic [2:0]  chr_idx;
  logic [7:0]  chr_reg;
  logic [7:0]  chr_v;
  logic [9:0]  chr_raw;
  logic [9:0]  chr_bank;

  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
    if (start) begin
      in_item_r <= in_item;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_last_r <= PRG_LAST_RST;
      chr_last_r <= CHR_LAST_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PRG_LAST) begin
        prg_last_r <= cfg_wdata[7:0];
      end else begin
        chr_last_r <= cfg_wdata;
      end
    end
  end

  // CPU write decode
  assign wr_code = in_item_r.address & WR_MASK;

  always_comb begin
    wr_outer = 1'b0;
    wr_bsel  = 1'b0;
    wr_bdata = 1'b0;
    if (in_vld_r && (in_item_r.req_type == REQ_WRITE)) begin
      unique case (wr_code) inside
        WR_OUT_90, WR_OUT_91, WR_OUT_B0, WR_OUT_B1,
        WR_OUT_D0, WR_OUT_D1, WR_OUT_F0, WR_OUT_F1: begin
          wr_outer = 1'b1;
        end
        WR_BSEL: begin
          wr_bsel = 1'b1;
        end
        WR_BDATA: begin
          wr_bdata = 1'b1;
        end
        default: begin
          wr_outer = 1'b0;
        end
      endcase
    end
  end

  // Mapper registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_r     <= '0;
      bsel_r      <= '0;
      bank_regs_r <= BANK_INIT;
    end else begin
      if (wr_outer) begin
        outer_r <= in_item_r.value;
      end
      if (wr_bsel) begin
        bsel_r <= in_item_r.value;
      end
      if (wr_bdata) begin
        bank_regs_r[bsel_r[2:0]] <= in_item_r.value;
      end
    end
  end

  // Program bank: swap mode picks the fixed 0x0E slot, outer bit4 picks MMC3 vs 32K
  assign prg_slot = in_item_r.address[14:13];

  always_comb begin
    case (prg_slot)
      2'd0:    prg_v = bsel_r[6] ? PRG_FIX_E : bank_regs_r[6];
      2'd1:    prg_v = bank_regs_r[7];
      2'd2:    prg_v = bsel_r[6] ? bank_regs_r[6] : PRG_FIX_E;
      default: prg_v = PRG_FIX_F;
    endcase
  end

  assign prg_raw  = outer_r[4] ? {2'b00, outer_r[3:2], prg_v[3:0]}
                               : {2'b00, outer_r[3:0], prg_slot};
  assign prg_bank = (prg_raw > prg_last_r) ? (prg_raw & prg_last_r) : prg_raw;

  // Pattern bank: A12 inversion, 2K pairs in the low half
  assign chr_slot = in_item_r.address[12:10] ^ {bsel_r[7], 2'b00};
  assign chr_idx  = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
  assign chr_reg  = bank_regs_r[chr_idx];

  always_comb begin
    if (chr_slot[2]) begin
      chr_v = chr_reg;
    end else if (chr_slot[0]) begin
      chr_v = chr_reg | 8'h01;
    end else begin
      chr_v = chr_reg & 8'hFE;
    end
  end

  assign chr_raw  = {1'b0, outer_r[3:2], chr_v[6:0]};
  assign chr_bank = (chr_raw > chr_last_r) ? (chr_raw & chr_last_r) : chr_raw;

  // Result select
  always_comb begin
    out_item_nxt.bank        = '0;
    out_item_nxt.write_taken = wr_outer | wr_bsel | wr_bdata;
    case (in_item_r.req_type)
      REQ_PRG: out_item_nxt.bank = {2'b00, prg_bank};
      REQ_CHR: out_item_nxt.bank = chr_bank;
      default: out_item_nxt.bank = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
    if (in_vld_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

[hdl/mcmmc3_chk.sv]
// Port-level checker for the multicart MMC3 bank mapper, with its bind.
// Depends on mcmmc3_pkg and multicart_mmc3_bank_mapper_assert.svh.
`include "multicart_mmc3_bank_mapper_assert.svh"

module mcmmc3_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input mcmmc3_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input mcmmc3_pkg::out_item_t out_item
);
  import mcmmc3_pkg::*;

  // Every accepted transaction yields one result
  `MCMMC3_ASSERT_D2(a_result_follows, start && !busy, out_valid)

  // No result without an earlier accepted transaction
  `MCMMC3_ASSERT_IMP(a_no_spurious, out_valid && $past(rst_n, 2), $past(start && !busy, 2))

  // A taken write reports bank zero
  `MCMMC3_ASSERT_IMP(a_write_bank_zero, out_valid && out_item.write_taken, out_item.bank == '0)

  // Queries never report a taken write
  `MCMMC3_ASSERT_D2(a_query_not_taken,
    start && !busy && (in_item.req_type != REQ_WRITE), !out_item.write_taken)

endmodule

bind multicart_mmc3_bank_mapper mcmmc3_chk u_mcmmc3_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[test/tb_multicart_mmc3_bank_mapper.sv]
// Self-checking testbench for multicart_mmc3_bank_mapper: directed table, then random traffic.
// Depends on mcmmc3_pkg and the mapper RTL; carries its own bank translation predictor.
module tb_multicart_mmc3_bank_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import mcmmc3_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR       = 25;
  localparam int N_PHASE     = 6;
  localparam int PHASE_TXNS  = 190;
  localparam int DRAIN_CYCS  = 8;

  // Directed row: stimulus, whether the result is typed in, and that result
  typedef struct packed {
    in_item_t  item;
    logic      chk;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic      cfg_index = CFG_PRG_LAST;
  logic [9:0] cfg_wdata = '0;

  // Predictor copy of the mapper state and limits
  logic [7:0] m_outer;
  logic [7:0] m_bsel;
  logic [7:0] m_regs [8];
  logic [7:0] m_prg_last;
  logic [9:0] m_chr_last;

  out_item_t pending_banks [$];
  int        n_mismatch = 0;
  int        n_orphan   = 0;
  int        n_txn      = 0;
  int        n_wr       = 0;
  int        n_prg      = 0;
  int        n_chr      = 0;
  int        n_taken    = 0;
  int        cyc        = 0;
  bit        idle_ok    = 1'b1;

  dir_row_t dir_tab [N_DIR] = '{
    '{'{REQ_PRG,   16'h8000, 8'h00}, 1'b1, '{10'd0, 1'b0}},
    '{'{REQ_PRG,   16'hE000, 8'hFF}, 1'b1, '{10'd3, 1'b0}},
    '{'{REQ_CHR,   16'h0000, 8'h00}, 1'b1, '{10'd0, 1'b0}},
    '{'{REQ_CHR,   16'h1C00, 8'h00}, 1'b1, '{10'd7, 1'b0}},
    '{'{REQ_NONE,  16'hFFFF, 8'hFF}, 1'b1, '{10'd0, 1'b0}},
    '{'{REQ_WRITE, 16'hA000, 8'hFF}, 1'b1, '{10'd0, 1'b0}},
    '{'{REQ_WRITE, 16'h8000, 8'h00}, 1'b1, '{10'd0, 1'b1}},
    '{'{REQ_WRITE, 16'h8001, 8'hFF}, 1'b1, '{10'd0, 1'b1}},
    '{'{REQ_CHR,   16'h0400, 8'h00}, 1'b0, '{10'd0, 1'b0}},
    '{'{REQ_CHR,   16'h0000, 8'h00}, 1'b0, '{10'd0, 1'b0}},
    '{'{REQ_WRITE, 16'h8000, 8'hC6}, 1'b1, '{10'd0, 1'b1}},
    '{'{REQ_WRITE, 16'h8001, 8'h3A}, 1'b1, '{10'd0, 1'b1}},
    '{'{REQ_WRITE, 16'h9000, 8'h1F}, 1'b1, '{10'd0, 1'b1}},
    '{'{REQ_PRG,   16'h8000, 8'h00}, 1'b0, '{10'd0, 1'b0}},
    '{'{REQ_PRG,   16'hC000, 8'h00}, 1'b0, '{10'd0, 1'b0}},
    '{'{REQ_PRG,   16'hFFFF, 8'hFF}, 1'b0, '{10'd0, 1'b0}},
    '{'{REQ_CHR,   16'hFFFF, 8'hFF}, 1'b0, '{10'd0, 1'b0}},
    '{'{REQ_WRITE, 16'hF001, 8'hFF}, 1'b1, '{10'd0, 1'b1}},
    '{'{REQ_PRG,   16'h6000, 8'h00}, 1'b0, '{10'd0, 1'b0}},
    '{'{REQ_CHR,   16'h0000, 8'h00}, 1'b0, '{10'd0, 1'b0}},
    '{'{REQ_WRITE, 16'hD001, 8'h00}, 1'b1, '{10'd0, 1'b1}},
    '{'{REQ_WRITE, 16'hBFFE, 8'h55}, 1'b1, '{10'd0, 1'b1}},
    '{'{REQ_WRITE, 16'h7001, 8'hAA}, 1'b1, '{10'd0, 1'b0}},
    '{'{REQ_WRITE, 16'hE000, 8'hFF}, 1'b1, '{10'd0, 1'b0}},
    '{'{REQ_PRG,   16'h0000, 8'h00}, 1'b0, '{10'd0, 1'b0}}
  };

  multicart_mmc3_bank_mapper uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Run guard
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [9:0] clip_bank(logic [9:0] b, logic [9:0] last);
    return (b > last) ? (b & last) : b;
  endfunction

  // Predict one transaction's result and apply its effect on the mapper state
  function automatic out_item_t translate_txn(in_item_t it);
    out_item_t  r;
    logic [1:0] slot;
    logic [2:0] cs;
    logic [7:0] v;
    logic [9:0] b;
    r = '0;
    case (it.req_type)
      REQ_WRITE: begin
        r.write_taken = 1'b1;
        case (it.address & WR_MASK)
          WR_OUT_90, WR_OUT_91, WR_OUT_B0, WR_OUT_B1,
          WR_OUT_D0, WR_OUT_D1, WR_OUT_F0, WR_OUT_F1: m_outer = it.value;
          WR_BSEL:  m_bsel = it.value;
          WR_BDATA: m_regs[m_bsel[2:0]] = it.value;
          default:  r.write_taken = 1'b0;
        endcase
      end
      REQ_PRG: begin
        slot = it.address[14:13];
        case (slot)
          2'd0:    v = m_bsel[6] ? PRG_FIX_E : m_regs[6];
          2'd1:    v = m_regs[7];
          2'd2:    v = m_bsel[6] ? m_regs[6] : PRG_FIX_E;
          default: v = PRG_FIX_F;
        endcase
        if (m_outer[4]) b = {4'b0, m_outer[3:2], v[3:0]};
        else b = {4'b0, m_outer[3:0], slot};
        r.bank = clip_bank(b, {2'b0, m_prg_last});
      end
      REQ_CHR: begin
        // A12 inversion swaps the lower and upper halves of the slot range
        cs = it.address[12:10] ^ {m_bsel[7], 2'b00};
        if (!cs[2]) begin
          v = m_regs[{2'b00, cs[1]}];
          v = cs[0] ? (v | 8'h01) : (v & 8'hFE);
        end else begin
          v = m_regs[cs - 3'd2];
        end
        b = {1'b0, m_outer[3:2], v[6:0]};
        r.bank = clip_bank(b, m_chr_last);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Drive one transaction, wait for acceptance, queue its expected result
  task automatic send_txn(in_item_t it, logic chk, out_item_t want);
    out_item_t pred;
    @(negedge clk);
    while (idle_ok && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pred = translate_txn(it);
    pending_banks.push_back(chk ? want : pred);
    n_txn++;
    case (it.req_type)
      REQ_WRITE: n_wr++;
      REQ_PRG:   n_prg++;
      REQ_CHR:   n_chr++;
      default: ;
    endcase
    if (it.req_type == REQ_WRITE && pred.write_taken) n_taken++;
  endtask

  // Stop input and let outstanding results drain
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_banks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Program both bank limits while the mapper is idle
  task automatic write_limits(logic [7:0] prg_last, logic [9:0] chr_last);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRG_LAST;
    cfg_wdata <= {2'b00, prg_last};
    @(negedge clk);
    cfg_index <= CFG_CHR_LAST;
    cfg_wdata <= chr_last;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_prg_last = prg_last;
    m_chr_last = chr_last;
  endtask

  // Mostly decodable writes and queries, with some noise
  function automatic in_item_t rand_txn();
    in_item_t   it;
    int         pick;
    logic [15:0] code;
    pick = $urandom_range(99);
    it.address = 16'($urandom);
    it.value   = 8'($urandom);
    if ($urandom_range(9) == 0) it.value = $urandom_range(1) ? 8'hFF : 8'h00;
    if (pick < 40) begin
      it.req_type = REQ_WRITE;
      case ($urandom_range(9))
        0:       code = WR_OUT_90;
        1:       code = WR_OUT_91;
        2:       code = WR_OUT_B0;
        3:       code = WR_OUT_B1;
        4:       code = WR_OUT_D0;
        5:       code = WR_OUT_D1;
        6:       code = WR_OUT_F0;
        7:       code = WR_OUT_F1;
        8:       code = WR_BSEL;
        default: code = WR_BDATA;
      endcase
      if ($urandom_range(2) == 0) code = WR_BDATA;
      it.address = code | (it.address & ~WR_MASK);
    end else if (pick < 48) begin
      it.req_type = REQ_WRITE;
    end else if (pick < 72) begin
      it.req_type = REQ_PRG;
    end else if (pick < 95) begin
      it.req_type = REQ_CHR;
    end else begin
      it.req_type = REQ_NONE;
    end
    return it;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_banks.size() == 0) begin
        n_orphan++;
        if (n_mismatch + n_orphan <= 10)
          $display("unexpected result bank=%0d taken=%0b", out_item.bank, out_item.write_taken);
      end else begin
        want = pending_banks.pop_front();
        if (out_item.bank !== want.bank || out_item.write_taken !== want.write_taken) begin
          n_mismatch++;
          if (n_mismatch + n_orphan <= 10)
            $display("mismatch: bank exp %0d got %0d, taken exp %0b got %0b",
                     want.bank, out_item.bank, want.write_taken, out_item.write_taken);
        end
      end
    end
  end

  logic [7:0] phase_prg [N_PHASE] = '{8'd255, 8'd0, 8'd1, 8'd0, 8'd15, 8'd63};
  logic [9:0] phase_chr [N_PHASE] = '{10'd1023, 10'd0, 10'd1, 10'd0, 10'd100, 10'd255};

  initial begin
    m_outer    = '0;
    m_bsel     = '0;
    m_regs     = BANK_INIT;
    m_prg_last = PRG_LAST_RST;
    m_chr_last = CHR_LAST_RST;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    write_limits(PRG_LAST_RST, CHR_LAST_RST);
    for (int i = 0; i < N_DIR; i++)
      send_txn(dir_tab[i].item, dir_tab[i].chk, dir_tab[i].want);

    for (int p = 0; p < N_PHASE; p++) begin
      if (p == 3) write_limits(8'($urandom), 10'($urandom));
      else write_limits(phase_prg[p], phase_chr[p]);
      for (int k = 0; k < PHASE_TXNS; k++) begin
        // a stretch without input gaps
        idle_ok = !(n_txn >= 400 && n_txn < 620);
        send_txn(rand_txn(), 1'b0, '0);
      end
    end
    idle_ok = 1'b1;

    drain_results();
    repeat (DRAIN_CYCS) @(posedge clk);
    $display("Ran %0d transactions: %0d writes (%0d taken), %0d program and %0d pattern queries,",
             n_txn, n_wr, n_taken, n_prg, n_chr);
    $display("across %0d bank limit settings; %0d mismatches, %0d unexpected results",
             N_PHASE + 1, n_mismatch, n_orphan);
    if (n_mismatch == 0 && n_orphan == 0 && pending_banks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mcmmc3_pkg.sv
hdl/multicart_mmc3_bank_mapper.sv
hdl/mcmmc3_chk.sv
test/tb_multicart_mmc3_bank_mapper.sv
